FILE: src/atrp_pkg.sv
// Package for the accelerometer tilt block: widths, lane codes, pipeline payload types
// and the CORDIC arctangent table. No dependencies.
`default_nettype none

package atrp_pkg;

  localparam int NLANE      = 2;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;

  localparam int AW   = 16;  // raw axis count
  localparam int NW   = AW + 1;  // numerator, holds +32768
  localparam int SW   = 2 * AW;  // sum of two squares
  localparam int MW   = 32;  // magnitude, 16 fraction bits
  localparam int RW   = MW + 4;  // square-root remainder
  localparam int XW   = 36;  // CORDIC x/y
  localparam int ZW   = 32;  // angle accumulator
  localparam int FRAC = 16;
  localparam int OW   = 15;  // output angle

  localparam int TABLE_LEN   = 24;
  localparam int ANGLE_LIMIT = 9000;

  // atan(2^-i) in units of 1/6553600 degree
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
    32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45
  };

  typedef struct packed {
    logic signed [NW-1:0] num;
    logic                 num_zero;
    logic                 mag_zero;
  } lane_ctl_t;

  typedef struct packed {
    logic [SW-1:0] sum;
    lane_ctl_t     ctl;
  } sum_t;

  typedef struct packed {
    logic [MW-1:0] mag;
    lane_ctl_t     ctl;
  } mag_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    lane_ctl_t            ctl;
  } ang_t;

endpackage

`default_nettype wire

FILE: src/atrp_ifs.sv
// Request channel interfaces of the accelerometer tilt block: raw sample in, angles out.
// Depends on nothing.
`default_nettype none

interface atrp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atrp_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] roll_angle;
  logic signed [14:0] pitch_angle;
  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

`default_nettype wire

FILE: src/accel_tilt_roll_pitch.sv
// Accelerometer tilt: roll = atan2(ay, sqrt(ax^2+az^2)), pitch = atan2(-ax, sqrt(ay^2+az^2)),
// both in hundredths of a degree, rounded and held within +/-9000. One sample is accepted
// per cycle unless the pipeline is full and the output is stalled. The stages are the squares
// and sums, the bit-per-stage square root, one CORDIC micro-rotation per stage (CORDIC_STAGES,
// capped at TABLE_LEN), then rounding and the output register. A stalled output
// holds the pipeline stage by stage, so empty stages keep filling while a result waits.
// Depends on atrp_pkg, atrp_ifs, atrp_square, atrp_sqrt and atrp_cordic.
`default_nettype none

module accel_tilt_roll_pitch #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  atrp_in_if.sink        in_i,
  atrp_out_if.source     out_o
);
  import atrp_pkg::*;

  localparam int QW = ZW + 1 - FRAC;
  localparam logic signed [ZW:0]   HALF = (ZW+1)'(1) <<< (FRAC - 1);
  localparam logic signed [QW-1:0] LIM  = QW'(ANGLE_LIMIT);

  sum_t [NLANE-1:0] sum_data;
  mag_t [NLANE-1:0] mag_data;
  ang_t [NLANE-1:0] ang_data;
  logic sq_valid, sq_ready, rt_valid, rt_ready, cd_valid, cd_ready;

  logic signed [OW-1:0] ang_d [NLANE];
  logic signed [OW-1:0] ang_q [NLANE];
  logic vout_q;

  atrp_square u_square (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .accel_x_i (in_i.accel_x),
    .accel_y_i (in_i.accel_y),
    .accel_z_i (in_i.accel_z),
    .valid_o   (sq_valid),
    .ready_i   (sq_ready),
    .data_o    (sum_data)
  );

  atrp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .data_i  (sum_data),
    .valid_o (rt_valid),
    .ready_i (rt_ready),
    .data_o  (mag_data)
  );

  atrp_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_valid),
    .ready_o (rt_ready),
    .data_i  (mag_data),
    .valid_o (cd_valid),
    .ready_i (cd_ready),
    .data_o  (ang_data)
  );

  assign cd_ready = ~vout_q | out_o.ready;

  // round half up, saturate, then the degenerate-argument cases
  always_comb begin
    logic signed [ZW:0]   zr;
    logic signed [QW-1:0] q;
    for (int l = 0; l < NLANE; l++) begin
      zr = $signed({ang_data[l].z[ZW-1], ang_data[l].z}) + HALF;
      q  = QW'(zr >>> FRAC);
      if (q > LIM) q = LIM;
      if (q < -LIM) q = -LIM;
      if (ang_data[l].ctl.num_zero) begin
        ang_d[l] = '0;
      end else if (ang_data[l].ctl.mag_zero) begin
        ang_d[l] = ang_data[l].ctl.num[NW-1] ? -OW'(ANGLE_LIMIT) : OW'(ANGLE_LIMIT);
      end else begin
        ang_d[l] = q[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (cd_ready) begin
      vout_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_ready) begin
      ang_q <= ang_d;
    end
  end

  assign out_o.valid       = vout_q;
  assign out_o.roll_angle  = ang_q[LANE_ROLL];
  assign out_o.pitch_angle = ang_q[LANE_PITCH];

  a_roll_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.roll_angle <= OW'(ANGLE_LIMIT)) &&
                    (out_o.roll_angle >= -OW'(ANGLE_LIMIT)))
    else $error("roll angle out of range");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.pitch_angle <= OW'(ANGLE_LIMIT)) &&
                    (out_o.pitch_angle >= -OW'(ANGLE_LIMIT)))
    else $error("pitch angle out of range");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled while output can move");

endmodule

`default_nettype wire

FILE: src/atrp_square.sv
// Front end: squares the three axes, then forms the two sums of squares (two stages).
// Depends on atrp_pkg.
`default_nettype none

module atrp_square (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [atrp_pkg::AW-1:0]         accel_x_i,
  input  logic signed [atrp_pkg::AW-1:0]         accel_y_i,
  input  logic signed [atrp_pkg::AW-1:0]         accel_z_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output atrp_pkg::sum_t [atrp_pkg::NLANE-1:0]   data_o
);
  import atrp_pkg::*;

  logic signed [SW-1:0] px, py, pz;
  logic [SW-2:0] sqx_q, sqy_q, sqz_q;
  lane_ctl_t [NLANE-1:0] ctl_d, ctl_q;
  sum_t [NLANE-1:0] sum_d, sum_q;
  logic v1_q, v2_q, en1, en2;

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;

  assign px = accel_x_i * accel_x_i;
  assign py = accel_y_i * accel_y_i;
  assign pz = accel_z_i * accel_z_i;

  always_comb begin
    ctl_d[LANE_ROLL].num       = {accel_y_i[AW-1], accel_y_i};
    ctl_d[LANE_ROLL].num_zero  = (accel_y_i == '0);
    ctl_d[LANE_ROLL].mag_zero  = (accel_x_i == '0) && (accel_z_i == '0);
    ctl_d[LANE_PITCH].num      = -{accel_x_i[AW-1], accel_x_i};
    ctl_d[LANE_PITCH].num_zero = (accel_x_i == '0);
    ctl_d[LANE_PITCH].mag_zero = (accel_y_i == '0) && (accel_z_i == '0);
  end

  always_comb begin
    sum_d[LANE_ROLL].sum  = {1'b0, sqx_q} + {1'b0, sqz_q};
    sum_d[LANE_ROLL].ctl  = ctl_q[LANE_ROLL];
    sum_d[LANE_PITCH].sum = {1'b0, sqy_q} + {1'b0, sqz_q};
    sum_d[LANE_PITCH].ctl = ctl_q[LANE_PITCH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sqx_q <= px[SW-2:0];
      sqy_q <= py[SW-2:0];
      sqz_q <= pz[SW-2:0];
      ctl_q <= ctl_d;
    end
    if (en2) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = sum_q;

endmodule

`default_nettype wire

FILE: src/atrp_sqrt.sv
// Pipelined square root, one result bit per stage: mag = floor(sqrt(sum * 2^32)).
// Both lanes run side by side. Depends on atrp_pkg.
`default_nettype none

module atrp_sqrt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  atrp_pkg::sum_t [atrp_pkg::NLANE-1:0] data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output atrp_pkg::mag_t [atrp_pkg::NLANE-1:0] data_o
);
  import atrp_pkg::*;

  typedef struct packed {
    logic [MW-1:0] root;
    logic [RW-1:0] rem;
    logic [SW-1:0] sum;
    lane_ctl_t     ctl;
  } root_lane_t;

  root_lane_t [NLANE-1:0] st_q [MW];
  root_lane_t [NLANE-1:0] nxt  [MW];
  logic [MW-1:0] v_q, en;

  for (genvar k = 0; k < MW; k++) begin : g_stage
    localparam int BI = MW - 1 - k;
    assign en[k] = ready_i | ~(&v_q[MW-1:k]);
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      root_lane_t prv;
      logic [1:0] pair;
      logic [RW-1:0] rem_sh, trial;
      logic ge;
      if (k == 0) begin : g_first
        assign prv = '{root: '0, rem: '0, sum: data_i[l].sum, ctl: data_i[l].ctl};
      end else begin : g_next
        assign prv = st_q[k-1][l];
      end
      if (2 * BI >= MW) begin : g_bits
        assign pair = prv.sum[2*BI-MW+1 -: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end
      assign rem_sh = {prv.rem[RW-3:0], pair};
      assign trial  = {{(RW-MW-2){1'b0}}, prv.root, 2'b01};
      assign ge     = (rem_sh >= trial);
      assign nxt[k][l] = '{root: {prv.root[MW-2:0], ge},
                           rem:  ge ? rem_sh - trial : rem_sh,
                           sum:  prv.sum,
                           ctl:  prv.ctl};
    end
  end

  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < MW; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MW; k++) begin
      if (en[k]) st_q[k] <= nxt[k];
    end
  end

  assign valid_o = v_q[MW-1];
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      data_o[l].mag = st_q[MW-1][l].root;
      data_o[l].ctl = st_q[MW-1][l].ctl;
    end
  end

endmodule

`default_nettype wire

FILE: src/atrp_cordic.sv
// CORDIC vectoring pipeline, one micro-rotation per stage, on (mag, num * 2^16).
// Both lanes run side by side. Depends on atrp_pkg.
`default_nettype none

module atrp_cordic #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  atrp_pkg::mag_t [atrp_pkg::NLANE-1:0] data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output atrp_pkg::ang_t [atrp_pkg::NLANE-1:0] data_o
);
  import atrp_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : int'(CORDIC_STAGES);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    lane_ctl_t            ctl;
  } rot_lane_t;

  rot_lane_t [NLANE-1:0] st_q [NSTG];
  rot_lane_t [NLANE-1:0] nxt  [NSTG];
  logic [NSTG-1:0] v_q, en;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    assign en[k] = ready_i | ~(&v_q[NSTG-1:k]);
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      rot_lane_t prv;
      logic signed [XW-1:0] xp, yp, xs, ys;
      logic signed [ZW-1:0] zp;
      logic neg;
      if (k == 0) begin : g_first
        assign prv = '{x:   {{(XW-MW){1'b0}}, data_i[l].mag},
                       y:   {{(XW-NW-FRAC){data_i[l].ctl.num[NW-1]}},
                             data_i[l].ctl.num, {FRAC{1'b0}}},
                       z:   '0,
                       ctl: data_i[l].ctl};
      end else begin : g_next
        assign prv = st_q[k-1][l];
      end
      assign xp  = prv.x;
      assign yp  = prv.y;
      assign zp  = prv.z;
      assign xs  = xp >>> k;
      assign ys  = yp >>> k;
      assign neg = yp[XW-1];
      assign nxt[k][l] = '{x:   neg ? xp - ys : xp + ys,
                           y:   neg ? yp + xs : yp - xs,
                           z:   neg ? zp - ATAN_TAB[k] : zp + ATAN_TAB[k],
                           ctl: prv.ctl};
    end
  end

  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) st_q[k] <= nxt[k];
    end
  end

  assign valid_o = v_q[NSTG-1];
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      data_o[l].z   = st_q[NSTG-1][l].z;
      data_o[l].ctl = st_q[NSTG-1][l].ctl;
    end
  end

endmodule

`default_nettype wire
